/* hdl/db9_pkg.sv */
// Shared types and constants for the DB9 pad scan and detect block.
// Used by db9_scan, db9_report and db9_pad_scan_and_detect; no dependencies.
package db9_pkg;

  localparam int PORT_W    = 8;
  localparam int LINE_W    = 6;
  localparam int AXIS_W    = 8;
  localparam int BTN_LO_W  = 6;
  localparam int BTN_HI_W  = 2;
  localparam int KIND_W    = 2;
  localparam int S_DATA_W  = 24;
  localparam int M_DATA_W  = 32;

  localparam logic [KIND_W-1:0] KIND_TWO_LINE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SMS      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GEN3     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_GEN6     = 2'd3;

  localparam logic [3:0] SIG_MULTITAP = 4'h3;
  localparam logic [3:0] SIG_ALL      = 4'hf;
  localparam logic [3:0] SIG_GEN      = 4'h3;

  localparam logic [AXIS_W-1:0] AXIS_LOW  = 8'd0;
  localparam logic [AXIS_W-1:0] AXIS_MID  = 8'd128;
  localparam logic [AXIS_W-1:0] AXIS_HIGH = 8'd255;

  typedef enum logic [3:0] {
    SLOT_IDLE = 4'd0,
    SLOT_1    = 4'd1,
    SLOT_2    = 4'd2,
    SLOT_3    = 4'd3,
    SLOT_4    = 4'd4,
    SLOT_5    = 4'd5,
    SLOT_6    = 4'd6,
    SLOT_7    = 4'd7,
    SLOT_8    = 4'd8
  } slot_t;

  typedef struct packed {
    logic              select_line;
    logic              busy;
    logic              finish;
    logic [KIND_W-1:0] pad_kind;
    logic              detect_done;
    logic              multitap;
  } scan_status_t;

  typedef struct packed {
    logic [BTN_HI_W-1:0] buttons_high;
    logic [BTN_LO_W-1:0] buttons_low;
    logic [AXIS_W-1:0]   y_axis;
    logic [AXIS_W-1:0]   x_axis;
  } report_t;

endpackage

/* hdl/db9_scan.sv */
// Scan slot sequencer, line sample store and pad type detection.
// Depends on db9_pkg.
module db9_scan (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic                         start_scan,
  input  logic [db9_pkg::PORT_W-1:0]   port_c,
  input  logic [db9_pkg::PORT_W-1:0]   port_b,
  output db9_pkg::scan_status_t        status,
  output logic [db9_pkg::LINE_W-1:0]   samp_a,
  output logic [db9_pkg::LINE_W-1:0]   samp_b,
  output logic [db9_pkg::LINE_W-1:0]   samp_c
);

  db9_pkg::slot_t slot, slot_next;
  logic [db9_pkg::KIND_W-1:0] pad_kind, pad_kind_next;
  logic detect_done, detect_done_next;
  logic multitap, multitap_next;
  logic [db9_pkg::LINE_W-1:0] line_a, line_b, line_c, line_d, line_e;
  logic [db9_pkg::LINE_W-1:0] lines;
  logic short_scan;
  logic done, sel;
  logic wr_a, wr_b, wr_c, wr_d, wr_e;
  logic [db9_pkg::KIND_W-1:0] kind_det;

  assign lines = {port_b[5], port_c[1], port_c[2], port_c[3], port_c[4], port_c[5]};
  assign short_scan = (pad_kind == db9_pkg::KIND_TWO_LINE) || (pad_kind == db9_pkg::KIND_SMS);

  always_comb begin
    slot_next = slot;
    case (slot)
      db9_pkg::SLOT_IDLE: slot_next = start_scan ? db9_pkg::SLOT_1 : db9_pkg::SLOT_IDLE;
      db9_pkg::SLOT_1:    slot_next = short_scan ? db9_pkg::SLOT_IDLE : db9_pkg::SLOT_2;
      db9_pkg::SLOT_2:    slot_next = db9_pkg::SLOT_3;
      db9_pkg::SLOT_3:    slot_next = db9_pkg::SLOT_4;
      db9_pkg::SLOT_4:    slot_next = db9_pkg::SLOT_5;
      db9_pkg::SLOT_5:    slot_next = db9_pkg::SLOT_6;
      db9_pkg::SLOT_6:    slot_next = db9_pkg::SLOT_7;
      db9_pkg::SLOT_7:    slot_next = db9_pkg::SLOT_8;
      default:            slot_next = db9_pkg::SLOT_IDLE;
    endcase
  end

  always_comb begin
    sel  = 1'b1;
    done = 1'b0;
    wr_a = 1'b0;
    wr_b = 1'b0;
    wr_c = 1'b0;
    wr_d = 1'b0;
    wr_e = 1'b0;
    case (slot)
      db9_pkg::SLOT_IDLE: sel = 1'b1;
      db9_pkg::SLOT_1: begin
        wr_a = 1'b1;
        done = short_scan;
        sel  = short_scan;
      end
      db9_pkg::SLOT_2: wr_b = 1'b1;
      db9_pkg::SLOT_3: sel = 1'b0;
      db9_pkg::SLOT_4: wr_d = 1'b1;
      db9_pkg::SLOT_5: sel = 1'b0;
      db9_pkg::SLOT_6: wr_e = 1'b1;
      db9_pkg::SLOT_7: begin
        wr_c = 1'b1;
        sel  = 1'b0;
      end
      default: done = 1'b1;
    endcase
  end

  // slot 1 of a short scan completes on the sample it takes
  assign samp_a = wr_a ? lines : line_a;
  assign samp_b = line_b;
  assign samp_c = line_c;

  always_comb begin
    kind_det = db9_pkg::KIND_SMS;
    if (samp_a[3:0] != db9_pkg::SIG_MULTITAP) begin
      if (samp_a[3:0] == db9_pkg::SIG_ALL && line_b[3:0] == db9_pkg::SIG_GEN) begin
        kind_det = (line_d[3:0] != db9_pkg::SIG_GEN || line_e[3:0] != db9_pkg::SIG_GEN)
                   ? db9_pkg::KIND_GEN6 : db9_pkg::KIND_GEN3;
      end
      if (!line_b[5]) begin
        kind_det = db9_pkg::KIND_GEN6;
      end
    end
  end

  always_comb begin
    pad_kind_next    = pad_kind;
    detect_done_next = detect_done;
    multitap_next    = multitap;
    if (done && !detect_done) begin
      pad_kind_next    = kind_det;
      detect_done_next = 1'b1;
      multitap_next    = multitap | (samp_a[3:0] == db9_pkg::SIG_MULTITAP);
    end
  end

  assign status.select_line = sel;
  assign status.busy        = (slot_next != db9_pkg::SLOT_IDLE);
  assign status.finish      = done && detect_done;
  assign status.pad_kind    = pad_kind_next;
  assign status.detect_done = detect_done_next;
  assign status.multitap    = multitap_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot        <= db9_pkg::SLOT_IDLE;
      pad_kind    <= db9_pkg::KIND_GEN3;
      detect_done <= 1'b0;
      multitap    <= 1'b0;
    end else if (step) begin
      slot        <= slot_next;
      pad_kind    <= pad_kind_next;
      detect_done <= detect_done_next;
      multitap    <= multitap_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (wr_a) line_a <= lines;
      if (wr_b) line_b <= lines;
      if (wr_c) line_c <= lines;
      if (wr_d) line_d <= lines;
      if (wr_e) line_e <= lines;
    end
  end

endmodule

/* hdl/db9_report.sv */
// Report builder: axes, per-type button map and change flag against the last report.
// Depends on db9_pkg.
module db9_report (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic                         finish,
  input  logic [db9_pkg::KIND_W-1:0]   pad_kind,
  input  logic [db9_pkg::LINE_W-1:0]   samp_a,
  input  logic [db9_pkg::LINE_W-1:0]   samp_b,
  input  logic [db9_pkg::LINE_W-1:0]   samp_c,
  output db9_pkg::report_t             report,
  output logic                         report_valid,
  output logic                         changed
);

  db9_pkg::report_t current, built;
  logic first_pending;
  logic [db9_pkg::LINE_W-1:0] d0, d1, d2;
  logic genesis;

  assign genesis = (pad_kind == db9_pkg::KIND_GEN3) || (pad_kind == db9_pkg::KIND_GEN6);
  assign d0 = ~samp_a;
  assign d1 = genesis ? ~samp_b : '0;
  assign d2 = genesis ? ~samp_c : '0;

  always_comb begin
    built.y_axis       = d0[1] ? db9_pkg::AXIS_HIGH
                       : (d0[0] ? db9_pkg::AXIS_LOW : db9_pkg::AXIS_MID);
    built.x_axis       = d0[3] ? db9_pkg::AXIS_HIGH
                       : (d0[2] ? db9_pkg::AXIS_LOW : db9_pkg::AXIS_MID);
    built.buttons_low  = '0;
    built.buttons_high = '0;
    case (pad_kind)
      db9_pkg::KIND_GEN3: begin
        built.buttons_low = {2'b00, d1[5], d0[5], d0[4], d1[4]};
      end
      db9_pkg::KIND_GEN6: begin
        built.buttons_low  = {d2[3], d1[4], d2[0], d0[5], d0[4], d2[1]};
        built.buttons_high = {d1[5], d2[2]};
      end
      default: begin
        built.buttons_low = {4'b0000, d0[5], d0[4]};
      end
    endcase
  end

  assign report       = finish ? built : current;
  assign report_valid = finish;
  assign changed      = finish && (first_pending || (built != current));

  always_ff @(posedge clk) begin
    if (rst) begin
      current       <= '0;
      first_pending <= 1'b1;
    end else if (step && finish) begin
      current       <= built;
      first_pending <= 1'b0;
    end
  end

endmodule

/* hdl/db9_pad_scan_and_detect.sv */
// Top level of the DB9 pad scan and detect block: input register, scan core, result register.
// Depends on db9_pkg, db9_scan and db9_report.
//
// Usage: send one word on s_axis per 20 us tick, carrying the raw port pins and a scan
// request. Every input word yields exactly one output word on m_axis, which holds the
// select level to drive during the next tick, the busy flag, and the pad report.
// The first scan after reset runs pad type detection and gives no report; each later
// scan ends with report_valid set and changed flagged against the previous report.
// A scan lasts 9 ticks for three- and six-button pads and 2 ticks otherwise.
// Two register stages lie between s_axis and m_axis: the input register, then the
// result register after the scan logic.
// Throughput: one word per clock cycle while m_axis does not stall; the scan state machine
// and report logic handle one tick per cycle between the two registers.
// Reset clears the scan to idle, pad kind to three-button, detection and report state.
// When m_axis stalls, the result register holds and the input register fills; s_tready
// drops only when both are full.
module db9_pad_scan_and_detect (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [0] start_scan, [8:1] port_c, [16:9] port_b, [23:17] zero
  input  logic [db9_pkg::S_DATA_W-1:0]   s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [0] select_line, [1] busy_res, [2] report_valid, [10:3] x_axis, [18:11] y_axis,
  // [24:19] buttons_low, [26:25] buttons_high, [27] changed, [29:28] pad_type,
  // [30] detect_done, [31] multitap
  output logic [db9_pkg::M_DATA_W-1:0]   m_tdata
);

  logic in_valid;
  logic [db9_pkg::S_DATA_W-1:0] in_data;
  logic adv, step;
  db9_pkg::scan_status_t status;
  db9_pkg::report_t report;
  logic report_valid, changed;
  logic [db9_pkg::LINE_W-1:0] samp_a, samp_b, samp_c;
  logic [db9_pkg::M_DATA_W-1:0] result;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = !in_valid || adv;
  assign step     = in_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) in_data <= s_tdata;
  end

  db9_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .start_scan (in_data[0]),
    .port_c     (in_data[8:1]),
    .port_b     (in_data[16:9]),
    .status     (status),
    .samp_a     (samp_a),
    .samp_b     (samp_b),
    .samp_c     (samp_c)
  );

  db9_report u_report (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .finish       (status.finish),
    .pad_kind     (status.pad_kind),
    .samp_a       (samp_a),
    .samp_b       (samp_b),
    .samp_c       (samp_c),
    .report       (report),
    .report_valid (report_valid),
    .changed      (changed)
  );

  assign result = {status.multitap, status.detect_done, status.pad_kind, changed,
                   report.buttons_high, report.buttons_low, report.y_axis, report.x_axis,
                   report_valid, status.busy, status.select_line};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) m_tdata <= result;
  end

endmodule
